// File: hw/rtl/ins_pkg.sv
// types and constants shared by the interval node store modules
// no dependencies
package ins_pkg;
  localparam int MaxIntervals = 64;
  localparam int MaxChildren = 16;
  localparam int ResultLimit = 64;
  localparam int IdxW = $clog2(MaxIntervals);
  localparam int CntW = $clog2(MaxIntervals + 1);
  localparam int CIdxW = (MaxChildren > 1) ? $clog2(MaxChildren) : 1;
  localparam int CCntW = $clog2(MaxChildren + 1);
  localparam int NhW = $clog2(ResultLimit);

  // config register byte addresses
  localparam logic [3:0] ADDR_OWN_SEQ = 4'd0;
  localparam logic [3:0] ADDR_NODE_BEGIN = 4'd8;

  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_FIND1 = 3'd1,
    KIND_FINDA = 3'd2,
    KIND_ADDC  = 3'd3,
    KIND_CHILD = 3'd4,
    KIND_CLOSE = 3'd5
  } kind_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EARLY = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic       capture;    // register the input word
    logic       do_add;     // write interval at count
    logic       do_addc;    // write child at count
    logic       do_close;   // close node
    logic       rd_int;     // read interval at scan index
    logic       rd_chd;     // read child at scan index
    logic       scan_clr;   // scan index to zero
    logic       scan_inc;   // advance scan index
    logic       ans_load;   // child answer from read data
    logic       hold_load;  // hold register from interval read data
    logic       out_load;   // output hit register from hold register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] kind;
    logic       int_full;
    logic       chd_full;
    logic       closed;
    logic       close_early;
    logic       int_end;    // scan index reached interval count
    logic       chd_end;
    logic       int_hit;    // registered read entry covers query
    logic       key_hit;
    logic       chd_le;     // registered child begin <= query
  } stat_t;
endpackage

// File: hw/rtl/interval_node_store.sv
// top level of the interval node store: config port, controller, datapath
// depends on ins_pkg, ins_ctrl, ins_datapath
// One input word at a time. Adds, child adds and close update the store (or
// report full or early) and send one status word. Find-one and find-all read
// and compare the stored intervals one after another (find-one stops at its
// hit), and an output stall can hold the scan; a child lookup reads the stored
// children in turn. Find-all sends one word per match, in store
// order, at most 64 words; each hit is held until the next one is found or the
// scan ends, so last lands on the final word. Write config only while idle.
module interval_node_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [47:0] begin_time,
  input  logic [47:0] end_time,
  input  logic [15:0] interval_key,
  input  logic [47:0] query_time,
  input  logic [31:0] child_sequence,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [47:0] hit_begin,
  output logic [47:0] hit_end,
  output logic [15:0] hit_key,
  output logic [31:0] child_answer,
  output logic        last
);
  import ins_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [31:0] own_seq;
  logic [47:0] nbt;
  logic [47:0] dp_begin, dp_end;
  logic [15:0] dp_key;
  logic [31:0] ans;
  logic hit_sel, ans_sel;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite &&
                  (paddr == ADDR_OWN_SEQ || paddr == ADDR_NODE_BEGIN);
  always_comb begin
    case (paddr)
      ADDR_OWN_SEQ:    prdata = {32'd0, own_seq};
      ADDR_NODE_BEGIN: prdata = {16'd0, nbt};
      default:         prdata = '0;
    endcase
  end

  ins_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .kind, .begin_time, .end_time, .interval_key, .query_time, .child_sequence,
    .cfg_we, .cfg_sel(paddr == ADDR_NODE_BEGIN), .cfg_data(pwdata[47:0]),
    .own_sequence(own_seq), .node_begin_time(nbt),
    .hit_begin(dp_begin), .hit_end(dp_end), .hit_key(dp_key), .child_answer(ans)
  );

  ins_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd, .stat, .status, .hit_sel, .ans_sel, .last
  );

  // hit registers change only when the next hit word is loaded
  assign hit_begin = hit_sel ? dp_begin : '0;
  assign hit_end = hit_sel ? dp_end : '0;
  assign hit_key = hit_sel ? dp_key : '0;
  assign child_answer = ans_sel ? ans : '0;
endmodule

// File: hw/rtl/ins_datapath.sv
// interval and child stores, scan index, compare logic and config registers
// depends on ins_pkg
module ins_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  ins_pkg::cmd_t        cmd,
  output ins_pkg::stat_t       stat,
  input  logic [2:0]           kind,
  input  logic [47:0]          begin_time,
  input  logic [47:0]          end_time,
  input  logic [15:0]          interval_key,
  input  logic [47:0]          query_time,
  input  logic [31:0]          child_sequence,
  input  logic                 cfg_we,
  input  logic                 cfg_sel,
  input  logic [47:0]          cfg_data,
  output logic [31:0]          own_sequence,
  output logic [47:0]          node_begin_time,
  output logic [47:0]          hit_begin,
  output logic [47:0]          hit_end,
  output logic [15:0]          hit_key,
  output logic [31:0]          child_answer
);
  import ins_pkg::*;

  logic [47:0] mem_begin [MaxIntervals];
  logic [47:0] mem_end [MaxIntervals];
  logic [15:0] mem_key [MaxIntervals];
  logic [47:0] cmem_begin [MaxChildren];
  logic [31:0] cmem_seq [MaxChildren];

  logic [2:0]  in_kind;
  logic [47:0] in_begin, in_end, in_query;
  logic [15:0] in_key;
  logic [31:0] in_cseq;
  logic [CntW-1:0]  interval_count;
  logic [CCntW-1:0] child_count;
  logic [CntW-1:0]  scan;
  logic [47:0] current_end;
  logic        closed_flag;
  logic [47:0] rd_begin, rd_end;
  logic [15:0] rd_key;
  logic [47:0] hold_begin, hold_end;
  logic [15:0] hold_key;
  logic [47:0] rc_begin;
  logic [31:0] rc_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_count <= '0;
      child_count <= '0;
      closed_flag <= 1'b0;
      current_end <= '0;
      own_sequence <= '0;
      node_begin_time <= '0;
      scan <= '0;
    end else begin
      if (cfg_we && !cfg_sel) own_sequence <= cfg_data[31:0];
      if (cfg_we && cfg_sel) begin
        node_begin_time <= cfg_data;
        if (interval_count == '0 && !closed_flag) current_end <= cfg_data;
      end
      if (cmd.do_add) begin
        interval_count <= interval_count + 1'b1;
        current_end <= in_end;
      end
      if (cmd.do_addc) child_count <= child_count + 1'b1;
      if (cmd.do_close) begin
        closed_flag <= 1'b1;
        current_end <= in_end;
      end
      if (cmd.scan_clr) scan <= '0;
      else if (cmd.scan_inc) scan <= scan + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_kind <= kind;
      in_begin <= begin_time;
      in_end <= end_time;
      in_key <= interval_key;
      in_query <= query_time;
      in_cseq <= child_sequence;
    end
    if (cmd.do_add) begin
      mem_begin[interval_count[IdxW-1:0]] <= in_begin;
      mem_end[interval_count[IdxW-1:0]] <= in_end;
      mem_key[interval_count[IdxW-1:0]] <= in_key;
    end
    if (cmd.do_addc) begin
      cmem_begin[child_count[CIdxW-1:0]] <= in_begin;
      cmem_seq[child_count[CIdxW-1:0]] <= in_cseq;
    end
    if (cmd.rd_int) begin
      rd_begin <= mem_begin[scan[IdxW-1:0]];
      rd_end <= mem_end[scan[IdxW-1:0]];
      rd_key <= mem_key[scan[IdxW-1:0]];
    end
    if (cmd.hold_load) begin
      hold_begin <= rd_begin;
      hold_end <= rd_end;
      hold_key <= rd_key;
    end
    // output copy stays put while the scan reads on
    if (cmd.out_load) begin
      hit_begin <= hold_begin;
      hit_end <= hold_end;
      hit_key <= hold_key;
    end
    if (cmd.rd_chd) begin
      rc_begin <= cmem_begin[scan[CIdxW-1:0]];
      rc_seq <= cmem_seq[scan[CIdxW-1:0]];
    end
    if (cmd.scan_clr) child_answer <= own_sequence;
    else if (cmd.ans_load) child_answer <= rc_seq;
  end

  always_comb begin
    stat.kind = in_kind;
    stat.int_full = (interval_count >= CntW'(MaxIntervals));
    stat.chd_full = (child_count >= CCntW'(MaxChildren));
    stat.closed = closed_flag;
    stat.close_early = (in_end < current_end);
    stat.int_end = (scan >= interval_count);
    stat.chd_end = (scan >= CntW'(child_count));
    stat.int_hit = (rd_end >= in_query) && (rd_begin <= in_query);
    stat.key_hit = (rd_key == in_key);
    stat.chd_le = (in_query >= rc_begin);
  end

  assert property (@(posedge clk) disable iff (rst)
    interval_count <= CntW'(MaxIntervals))
    else $error("interval count past depth");
  assert property (@(posedge clk) disable iff (rst)
    child_count <= CCntW'(MaxChildren))
    else $error("child count past depth");
  assert property (@(posedge clk) disable iff (rst)
    cmd.do_add |=> closed_flag == $past(closed_flag))
    else $error("add changed close flag");
endmodule

// File: hw/rtl/ins_ctrl.sv
// sequencer for one input word: capture, scan, result output register
// depends on ins_pkg
module ins_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ins_pkg::cmd_t     cmd,
  input  ins_pkg::stat_t    stat,
  output logic [1:0]        status,
  output logic              hit_sel,
  output logic              ans_sel,
  output logic              last
);
  import ins_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_DEC  = 8'b00000010,
    S_IRD  = 8'b00000100,
    S_ICHK = 8'b00001000,
    S_FIN  = 8'b00010000,
    S_CRD  = 8'b00100000,
    S_CCHK = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic out_valid_next;
  logic [NhW-1:0] nhits, nhits_next;  // find-all words sent before the held hit
  logic held, held_next;              // a hit waits in the hold register
  logic [1:0] status_next;
  logic hit_sel_next, ans_sel_next, last_next;
  logic out_free;
  logic match;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      nhits <= '0;
      held <= 1'b0;
      status <= ST_OK;
      hit_sel <= 1'b0;
      ans_sel <= 1'b0;
      last <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      nhits <= nhits_next;
      held <= held_next;
      status <= status_next;
      hit_sel <= hit_sel_next;
      ans_sel <= ans_sel_next;
      last <= last_next;
    end
  end

  // a find-all hit is held until the next hit or the end of the scan,
  // so last can be set on the final word
  always_comb begin
    state_next = state;
    cmd = '0;
    out_valid_next = out_valid && out_stall;
    nhits_next = nhits;
    held_next = held;
    status_next = status;
    hit_sel_next = hit_sel;
    ans_sel_next = ans_sel;
    last_next = last;
    in_stall = (state != S_IDLE) || out_valid;
    match = stat.int_hit && (stat.kind == KIND_FINDA || stat.key_hit);
    case (state)
      S_IDLE: begin
        if (in_valid && !out_valid) begin
          cmd.capture = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.scan_clr = 1'b1;
        nhits_next = '0;
        held_next = 1'b0;
        hit_sel_next = 1'b0;
        ans_sel_next = 1'b0;
        last_next = 1'b1;
        status_next = ST_OK;
        case (stat.kind)
          KIND_ADD: begin
            cmd.do_add = !stat.int_full;
            if (stat.int_full) status_next = ST_FULL;
            out_valid_next = 1'b1;
            state_next = S_OUT;
          end
          KIND_ADDC: begin
            cmd.do_addc = !stat.chd_full;
            if (stat.chd_full) status_next = ST_FULL;
            out_valid_next = 1'b1;
            state_next = S_OUT;
          end
          KIND_CLOSE: begin
            cmd.do_close = !stat.closed && !stat.close_early;
            if (!stat.closed && stat.close_early) status_next = ST_EARLY;
            out_valid_next = 1'b1;
            state_next = S_OUT;
          end
          KIND_FIND1, KIND_FINDA: state_next = S_IRD;
          KIND_CHILD: state_next = S_CRD;
          default: state_next = S_IDLE;
        endcase
      end
      S_IRD: begin
        if (stat.int_end) begin
          if (held) begin
            state_next = S_FIN;
          end else begin
            // nothing matched, nothing sent yet
            status_next = ST_NONE;
            last_next = 1'b1;
            out_valid_next = 1'b1;
            state_next = S_OUT;
          end
        end else begin
          cmd.rd_int = 1'b1;
          cmd.scan_inc = 1'b1;
          state_next = S_ICHK;
        end
      end
      S_ICHK: begin
        if (!match) begin
          state_next = S_IRD;
        end else if (stat.kind == KIND_FIND1 || !held) begin
          cmd.hold_load = 1'b1;
          held_next = 1'b1;
          state_next = (stat.kind == KIND_FIND1) ? S_FIN : S_IRD;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          status_next = ST_OK;
          hit_sel_next = 1'b1;
          if (nhits == NhW'(ResultLimit - 1)) begin
            // held hit is the last one allowed, this one is dropped
            last_next = 1'b1;
            state_next = S_OUT;
          end else begin
            last_next = 1'b0;
            nhits_next = nhits + 1'b1;
            cmd.hold_load = 1'b1;
            state_next = S_IRD;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          status_next = ST_OK;
          hit_sel_next = 1'b1;
          last_next = 1'b1;
          state_next = S_OUT;
        end
      end
      S_CRD: begin
        if (stat.chd_end) begin
          out_valid_next = 1'b1;
          ans_sel_next = 1'b1;
          status_next = ST_OK;
          last_next = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.rd_chd = 1'b1;
          cmd.scan_inc = 1'b1;
          state_next = S_CCHK;
        end
      end
      S_CCHK: begin
        if (stat.chd_le) cmd.ans_load = 1'b1;
        if (stat.chd_le && !stat.chd_end) begin
          state_next = S_CRD;
        end else begin
          out_valid_next = 1'b1;
          ans_sel_next = 1'b1;
          status_next = ST_OK;
          last_next = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(last))
    else $error("output word changed under stall");
  assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> state == S_IDLE && !out_valid)
    else $error("capture while busy");
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_add, cmd.do_addc, cmd.do_close}))
    else $error("more than one store update");
endmodule
